// ===== hdl/kbnpt_pkg.sv =====
// shared types, constants and helper functions of the keyboard note tracker
`default_nettype none

package kbnpt_pkg;

   // fixed field widths
   localparam int KEY_W = 33;
   localparam int IDX_W = 6;
   localparam int VEC_W = 64;

   // opcode of an input beat
   typedef enum logic [1:0] {
      OP_FRAME     = 2'd0,
      OP_KILL      = 2'd1,
      OP_NO_ATTACK = 2'd2
   } op_type;

   // per-note state
   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_PRESSED  = 3'd1,
      ST_HELD     = 3'd2,
      ST_RELEASED = 3'd3,
      ST_STILL    = 3'd4
   } note_state_type;

   typedef struct packed {
      op_type             opcode;
      logic [KEY_W-1:0]   key_mask;
      logic               octave_changed;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0]   pressed_mask;
      logic [KEY_W-1:0]   held_mask;
      logic [KEY_W-1:0]   released_mask;
      logic [KEY_W-1:0]   still_released_mask;
      logic [IDX_W-1:0]   current_note;
      logic               current_valid;
      logic [IDX_W-1:0]   last_note;
      logic               last_note_valid;
      note_state_type     last_note_state;
      logic               legato;
      logic               any_pressed;
   } rsp_type;

   // note played in the previous frame
   typedef struct packed {
      logic [IDX_W-1:0]   note;
      logic               valid;
      note_state_type     state;
   } prior_type;

   // what the update logic does this cycle
   typedef struct packed {
      logic item;
      logic csr_kill;
      logic chord;
   } ctl_type;

   // isolate the lowest set bit
   function automatic logic [VEC_W-1:0] lowest_hot(input logic [VEC_W-1:0] v);
      lowest_hot = v & (~v + VEC_W'(1));
   endfunction

   // isolate the highest set bit through a bit reversal
   function automatic logic [VEC_W-1:0] highest_hot(input logic [VEC_W-1:0] v);
      logic [VEC_W-1:0] rev;
      logic [VEC_W-1:0] low;
      for (int n = 0; n < VEC_W; n++) begin
         rev[n] = v[VEC_W-1-n];
      end
      low = lowest_hot(rev);
      for (int n = 0; n < VEC_W; n++) begin
         highest_hot[n] = low[VEC_W-1-n];
      end
   endfunction

   // index of a one-hot vector, zero when empty
   function automatic logic [IDX_W-1:0] hot_index(input logic [VEC_W-1:0] v);
      hot_index = '0;
      for (int n = 0; n < VEC_W; n++) begin
         if (v[n]) begin
            hot_index = hot_index | IDX_W'(n);
         end
      end
   endfunction

endpackage

`default_nettype wire

// ===== hdl/kbnpt_next.sv =====
// next note states, keys and prior note for one beat or a mode write
`default_nettype none

module kbnpt_next #(
   parameter int NUM_NOTES = 33
) (
   input  kbnpt_pkg::ctl_type        ctl,
   input  kbnpt_pkg::req_type        req,
   input  logic [NUM_NOTES-1:0]      keys,
   input  kbnpt_pkg::note_state_type states [NUM_NOTES],
   input  kbnpt_pkg::prior_type      prior,
   output logic [NUM_NOTES-1:0]      keys_nx,
   output kbnpt_pkg::note_state_type states_nx [NUM_NOTES],
   output kbnpt_pkg::prior_type      prior_nx
);

   localparam int VW = kbnpt_pkg::VEC_W;

   logic [VW-1:0]            key_ext;
   logic [NUM_NOTES-1:0]     cur_k;
   logic [VW-1:0]            act0;
   logic [VW-1:0]            cur0_hot;
   logic [VW-1:0]            top0_hot;
   kbnpt_pkg::note_state_type cur0_state;
   kbnpt_pkg::note_state_type top0_state;
   logic [VW-1:0]            newp;
   logic [VW-1:0]            stop_hot;
   logic [VW-1:0]            below;
   logic [VW-1:0]            held_hot;
   logic                     held_any;
   logic                     rel_any;
   kbnpt_pkg::note_state_type s1 [NUM_NOTES];
   kbnpt_pkg::note_state_type chord_st [NUM_NOTES];
   logic [VW-1:0]            act1;
   logic [VW-1:0]            cur1_hot;
   logic [VW-1:0]            top1_hot;
   kbnpt_pkg::note_state_type top1_state;
   logic                     oct_eff;
   logic [VW-1:0]            press_hot;
   logic                     press_any;
   logic                     held_eff;

   // keys of notes beyond the key field read as up
   assign key_ext = VW'(req.key_mask);
   always_comb begin
      for (int n = 0; n < NUM_NOTES; n++) begin
         cur_k[n] = key_ext[n];
      end
   end

   // active notes and their extremes before the update
   always_comb begin
      act0       = '0;
      cur0_state = kbnpt_pkg::ST_IDLE;
      top0_state = kbnpt_pkg::ST_IDLE;
      for (int n = 0; n < NUM_NOTES; n++) begin
         act0[n] = (states[n] == kbnpt_pkg::ST_PRESSED) || (states[n] == kbnpt_pkg::ST_HELD);
      end
      cur0_hot = kbnpt_pkg::lowest_hot(act0);
      top0_hot = kbnpt_pkg::highest_hot(act0);
      for (int n = 0; n < NUM_NOTES; n++) begin
         if (cur0_hot[n]) begin
            cur0_state = kbnpt_pkg::note_state_type'(cur0_state | states[n]);
         end
         if (top0_hot[n]) begin
            top0_state = kbnpt_pkg::note_state_type'(top0_state | states[n]);
         end
      end
   end

   // solo scan: upward until the first new press
   always_comb begin
      newp = '0;
      for (int n = 0; n < NUM_NOTES; n++) begin
         newp[n] = ~keys[n] & cur_k[n];
      end
      stop_hot = kbnpt_pkg::lowest_hot(newp);
      below    = (|newp) ? (stop_hot - VW'(1)) : '1;
      held_hot = '0;
      rel_any  = 1'b0;
      for (int n = 0; n < NUM_NOTES; n++) begin
         held_hot[n] = keys[n] & cur_k[n] & below[n];
         rel_any     = rel_any | (keys[n] & ~cur_k[n] & below[n]);
      end
      held_any = |held_hot;
      held_hot = kbnpt_pkg::highest_hot(held_hot);
      for (int n = 0; n < NUM_NOTES; n++) begin
         s1[n] = states[n];
         if (below[n]) begin
            if (keys[n] && !cur_k[n]) begin
               s1[n] = kbnpt_pkg::ST_RELEASED;
            end else if (!keys[n] && !cur_k[n]) begin
               s1[n] = kbnpt_pkg::ST_STILL;
            end
         end
      end
   end

   // active notes after the scan
   always_comb begin
      act1       = '0;
      top1_state = kbnpt_pkg::ST_IDLE;
      for (int n = 0; n < NUM_NOTES; n++) begin
         act1[n] = (s1[n] == kbnpt_pkg::ST_PRESSED) || (s1[n] == kbnpt_pkg::ST_HELD);
      end
      cur1_hot = kbnpt_pkg::lowest_hot(act1);
      top1_hot = kbnpt_pkg::highest_hot(act1);
      for (int n = 0; n < NUM_NOTES; n++) begin
         if (top1_hot[n]) begin
            top1_state = kbnpt_pkg::note_state_type'(top1_state | s1[n]);
         end
      end
      // octave change retriggers the held note in place of a new press
      oct_eff   = req.octave_changed & (|act1);
      press_hot = oct_eff ? held_hot : stop_hot;
      press_any = oct_eff ? held_any : (|newp);
      held_eff  = ~oct_eff & held_any;
   end

   // chord mode: each note follows its own key edges
   always_comb begin
      for (int n = 0; n < NUM_NOTES; n++) begin
         chord_st[n] = states[n];
         if (states[n] == kbnpt_pkg::ST_RELEASED) begin
            chord_st[n] = kbnpt_pkg::ST_STILL;
         end else if (keys[n] && cur_k[n]) begin
            chord_st[n] = kbnpt_pkg::ST_HELD;
         end else if (!keys[n] && cur_k[n]) begin
            chord_st[n] = kbnpt_pkg::ST_PRESSED;
         end else if (keys[n] && !cur_k[n]) begin
            chord_st[n] = kbnpt_pkg::ST_RELEASED;
         end
      end
   end

   // select the update
   always_comb begin
      keys_nx  = keys;
      prior_nx = prior;
      for (int n = 0; n < NUM_NOTES; n++) begin
         states_nx[n] = states[n];
      end
      if (ctl.csr_kill || (ctl.item && req.opcode == kbnpt_pkg::OP_KILL)) begin
         // kill all, solo mode remembers the state of the highest active note
         if (!ctl.chord && (|act0)) begin
            prior_nx.state = top0_state;
         end
         for (int n = 0; n < NUM_NOTES; n++) begin
            states_nx[n] = kbnpt_pkg::ST_IDLE;
         end
      end else if (ctl.item) begin
         case (req.opcode)
            kbnpt_pkg::OP_FRAME: begin
               keys_nx = cur_k;
               if (ctl.chord) begin
                  for (int n = 0; n < NUM_NOTES; n++) begin
                     states_nx[n] = chord_st[n];
                  end
               end else begin
                  if (|act0) begin
                     prior_nx.note  = kbnpt_pkg::hot_index(cur0_hot);
                     prior_nx.valid = 1'b1;
                     prior_nx.state = cur0_state;
                  end else begin
                     prior_nx.state = kbnpt_pkg::ST_IDLE;
                  end
                  if (press_any || held_eff) begin
                     if (|act1) begin
                        prior_nx.state = top1_state;
                     end
                  end
                  for (int n = 0; n < NUM_NOTES; n++) begin
                     states_nx[n] = s1[n];
                     if (press_any) begin
                        states_nx[n] = press_hot[n] ? kbnpt_pkg::ST_PRESSED
                                                    : kbnpt_pkg::ST_IDLE;
                     end else if (held_eff) begin
                        states_nx[n] = kbnpt_pkg::ST_IDLE;
                        if (rel_any) begin
                           if (held_hot[n]) begin
                              states_nx[n] = (held_hot == cur1_hot) ? kbnpt_pkg::ST_HELD
                                                                    : kbnpt_pkg::ST_PRESSED;
                           end
                        end else if (cur1_hot[n]) begin
                           states_nx[n] = kbnpt_pkg::ST_HELD;
                        end
                     end
                  end
               end
            end
            kbnpt_pkg::OP_NO_ATTACK: begin
               // current note loses its attack
               if ((|act0) && cur0_state == kbnpt_pkg::ST_PRESSED) begin
                  for (int n = 0; n < NUM_NOTES; n++) begin
                     if (cur0_hot[n]) begin
                        states_nx[n] = kbnpt_pkg::ST_HELD;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hdl/kbnpt_report.sv =====
// result fields derived from the note states and the prior note
`default_nettype none

module kbnpt_report #(
   parameter int NUM_NOTES = 33
) (
   input  kbnpt_pkg::note_state_type states [NUM_NOTES],
   input  kbnpt_pkg::prior_type      prior,
   output kbnpt_pkg::rsp_type        rsp
);

   localparam int VW = kbnpt_pkg::VEC_W;
   localparam int KW = kbnpt_pkg::KEY_W;

   logic [VW-1:0]             m_pressed;
   logic [VW-1:0]             m_held;
   logic [VW-1:0]             m_rel;
   logic [VW-1:0]             m_still;
   logic [VW-1:0]             cur_hot;
   kbnpt_pkg::note_state_type cur_state;

   // one mask per state
   always_comb begin
      m_pressed = '0;
      m_held    = '0;
      m_rel     = '0;
      m_still   = '0;
      cur_state = kbnpt_pkg::ST_IDLE;
      for (int n = 0; n < NUM_NOTES; n++) begin
         m_pressed[n] = (states[n] == kbnpt_pkg::ST_PRESSED);
         m_held[n]    = (states[n] == kbnpt_pkg::ST_HELD);
         m_rel[n]     = (states[n] == kbnpt_pkg::ST_RELEASED);
         m_still[n]   = (states[n] == kbnpt_pkg::ST_STILL);
      end
      cur_hot = kbnpt_pkg::lowest_hot(m_pressed | m_held);
      for (int n = 0; n < NUM_NOTES; n++) begin
         if (cur_hot[n]) begin
            cur_state = kbnpt_pkg::note_state_type'(cur_state | states[n]);
         end
      end
   end

   // pack the result beat
   always_comb begin
      rsp.pressed_mask        = m_pressed[KW-1:0];
      rsp.held_mask           = m_held[KW-1:0];
      rsp.released_mask       = m_rel[KW-1:0];
      rsp.still_released_mask = m_still[KW-1:0];
      rsp.current_note        = kbnpt_pkg::hot_index(cur_hot);
      rsp.current_valid       = |cur_hot;
      rsp.last_note           = prior.note;
      rsp.last_note_valid     = prior.valid;
      rsp.last_note_state     = prior.state;
      rsp.legato              = (prior.state == kbnpt_pkg::ST_HELD) && (|cur_hot)
                                && (cur_state == kbnpt_pkg::ST_PRESSED);
      rsp.any_pressed         = |m_pressed;
   end

endmodule

`default_nettype wire

// ===== hdl/keyboard_note_priority_tracker.sv =====
// the note state file updates as a beat leaves the input register; its response is registered
// throughput: one beat per cycle while the receiver keeps rsp_ready high
// a mode write is taken only when both stages are empty and kills all notes
// reset: synchronous, clears all note states to idle, keys, prior note, mode (solo) and stages
`default_nettype none

module keyboard_note_priority_tracker #(
   parameter int NUM_NOTES = 33
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  kbnpt_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output kbnpt_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_data
);

   logic                      in_valid_ff, in_valid_in;
   kbnpt_pkg::req_type        in_data_ff, in_data_in;
   logic                      out_valid_ff, out_valid_in;
   kbnpt_pkg::rsp_type        out_data_ff, out_data_in;
   logic                      chord_ff, chord_in;
   logic [NUM_NOTES-1:0]      keys_ff, keys_in;
   kbnpt_pkg::note_state_type states_ff [NUM_NOTES];
   kbnpt_pkg::note_state_type states_in [NUM_NOTES];
   kbnpt_pkg::prior_type      prior_ff, prior_in;
   kbnpt_pkg::rsp_type        rsp_nx;
   kbnpt_pkg::ctl_type        ctl;
   logic                      advance;
   logic                      req_beat;
   logic                      csr_beat;

   // handshakes
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign csr_ready = ~in_valid_ff & ~out_valid_ff;
   assign req_beat  = req_valid & req_ready;
   assign csr_beat  = csr_valid & csr_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign ctl.item     = advance;
   assign ctl.csr_kill = csr_beat;
   assign ctl.chord    = chord_in;

   // state update
   kbnpt_next #(
      .NUM_NOTES (NUM_NOTES)
   ) u_next (
      .ctl       (ctl),
      .req       (in_data_ff),
      .keys      (keys_ff),
      .states    (states_ff),
      .prior     (prior_ff),
      .keys_nx   (keys_in),
      .states_nx (states_in),
      .prior_nx  (prior_in)
   );

   // result fields from the updated state
   kbnpt_report #(
      .NUM_NOTES (NUM_NOTES)
   ) u_report (
      .states (states_in),
      .prior  (prior_in),
      .rsp    (rsp_nx)
   );

   // stage next values
   always_comb begin
      chord_in     = csr_beat ? csr_data : chord_ff;
      in_valid_in  = req_beat | (in_valid_ff & ~advance);
      in_data_in   = req_beat ? req_data : in_data_ff;
      out_valid_in = advance | (out_valid_ff & ~rsp_ready);
      out_data_in  = advance ? rsp_nx : out_data_ff;
   end

   // registers
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         chord_ff     <= 1'b0;
         keys_ff      <= '0;
         prior_ff     <= '{note: '0, valid: 1'b0, state: kbnpt_pkg::ST_IDLE};
         for (int n = 0; n < NUM_NOTES; n++) begin
            states_ff[n] <= kbnpt_pkg::ST_IDLE;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         chord_ff     <= chord_in;
         keys_ff      <= keys_in;
         prior_ff     <= prior_in;
         for (int n = 0; n < NUM_NOTES; n++) begin
            states_ff[n] <= states_in[n];
         end
      end
   end

   // solo mode never sounds more than one note
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !chord_ff) |->
         ($countones(rsp_data.pressed_mask | rsp_data.held_mask) <= 1))
      else $error("solo mode reports more than one active note");

   // no current note means a zero index and no legato
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.current_valid) |->
         (rsp_data.current_note == '0 && !rsp_data.legato))
      else $error("current note fields set without a current note");

   // prior note stays zero until a note has been played
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_note_valid) |-> (rsp_data.last_note == '0))
      else $error("last note set before any note was played");

   // a waiting input beat is kept until it moves on
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("input stage lost a waiting beat");

   // a mode write leaves every note idle
   assert property (@(posedge clock) disable iff (reset)
      csr_beat |=> ($countones(rsp_nx.pressed_mask | rsp_nx.held_mask) == 0 || in_valid_ff))
      else $error("mode write left a note active");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench of the keyboard note priority tracker: directed table, then random frames vs a predictor
module tb_top;

   localparam int NOTES        = 33;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 245;
   localparam int DRAIN_CYCLES = 4;
   localparam int LONG_HOLD    = 300;
   localparam int DIR_ROWS     = 27;

   localparam kbnpt_pkg::op_type OP_UNUSED = kbnpt_pkg::op_type'(2'd3);
   localparam logic [kbnpt_pkg::KEY_W-1:0] KEYS_ALL = '1;
   localparam kbnpt_pkg::rsp_type RSP_NONE = '0;
   localparam kbnpt_pkg::rsp_type RSP_ALL_STILL = '{
      pressed_mask: '0, held_mask: '0, released_mask: '0, still_released_mask: KEYS_ALL,
      current_note: '0, current_valid: 1'b0, last_note: '0, last_note_valid: 1'b0,
      last_note_state: kbnpt_pkg::ST_IDLE, legato: 1'b0, any_pressed: 1'b0};

   typedef enum bit {ROW_ITEM, ROW_MODE} row_kind_type;
   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_pattern_type;

   typedef struct packed {
      row_kind_type                  kind;
      logic                          mode;
      kbnpt_pkg::op_type             op;
      logic [kbnpt_pkg::KEY_W-1:0]   keys;
      logic                          octave;
      logic                          typed;
      kbnpt_pkg::rsp_type            want;
   } dir_row_type;

   // directed rows: typed expectations only right after reset
   localparam dir_row_type DIR_TAB [DIR_ROWS] = '{
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_KILL,      33'h0,         1'b0, 1'b1, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_NO_ATTACK, 33'h0,         1'b0, 1'b1, RSP_NONE},
      '{ROW_ITEM, 1'b0, OP_UNUSED,               KEYS_ALL,      1'b1, 1'b1, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_FRAME,     33'h0,         1'b0, 1'b1, RSP_ALL_STILL},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_FRAME,     33'h1,         1'b0, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_FRAME,     33'h1,         1'b0, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_FRAME,     33'h100000001, 1'b0, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_FRAME,     33'h100000001, 1'b1, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_FRAME,     33'h1,         1'b0, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_FRAME,     33'h0,         1'b0, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_FRAME,     KEYS_ALL,      1'b0, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_FRAME,     KEYS_ALL,      1'b1, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_NO_ATTACK, 33'h0,         1'b0, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_FRAME,     33'h20,        1'b0, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_NO_ATTACK, KEYS_ALL,      1'b1, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_FRAME,     33'h28,        1'b1, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_FRAME,     33'h08,        1'b0, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_KILL,      KEYS_ALL,      1'b0, 1'b0, RSP_NONE},
      '{ROW_MODE, 1'b1, kbnpt_pkg::OP_FRAME,     33'h0,         1'b0, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_FRAME,     KEYS_ALL,      1'b0, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_FRAME,     KEYS_ALL,      1'b1, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_FRAME,     33'h0,         1'b0, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_FRAME,     KEYS_ALL,      1'b0, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_FRAME,     33'h0AAAAAAAA, 1'b0, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_FRAME,     33'h155555555, 1'b0, 1'b0, RSP_NONE},
      '{ROW_ITEM, 1'b0, kbnpt_pkg::OP_KILL,      33'h0,         1'b0, 1'b0, RSP_NONE},
      '{ROW_MODE, 1'b0, kbnpt_pkg::OP_FRAME,     33'h0,         1'b0, 1'b0, RSP_NONE}
   };

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   kbnpt_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   kbnpt_pkg::rsp_type rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_data;

   // predictor state
   kbnpt_pkg::note_state_type   note_st [NOTES];
   logic [kbnpt_pkg::KEY_W-1:0] keys_prev;
   logic [kbnpt_pkg::KEY_W-1:0] keys_now;
   logic [kbnpt_pkg::IDX_W-1:0] prior_note;
   logic                        prior_valid;
   kbnpt_pkg::note_state_type   prior_st;
   logic                        chord_on;

   kbnpt_pkg::rsp_type          rsp_due [$];
   int                          mismatches = 0;
   int                          cycles = 0;
   int                          burst_left = 0;
   logic [kbnpt_pkg::KEY_W-1:0] stim_keys = '0;
   bit                          long_hold_arm = 1'b0;

   keyboard_note_priority_tracker u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic bit note_active(int n);
      return note_st[n] == kbnpt_pkg::ST_PRESSED || note_st[n] == kbnpt_pkg::ST_HELD;
   endfunction

   function automatic int lowest_active();
      for (int n = 0; n < NOTES; n++) begin
         if (note_active(n)) return n;
      end
      return -1;
   endfunction

   // solo mode remembers the state of the highest sounding note
   function automatic void silence_all();
      for (int n = 0; n < NOTES; n++) begin
         if (!chord_on && note_active(n)) prior_st = note_st[n];
         note_st[n] = kbnpt_pkg::ST_IDLE;
      end
   endfunction

   function automatic void notes_reset();
      for (int n = 0; n < NOTES; n++) note_st[n] = kbnpt_pkg::ST_IDLE;
      keys_prev   = '0;
      keys_now    = '0;
      prior_note  = '0;
      prior_valid = 1'b0;
      prior_st    = kbnpt_pkg::ST_IDLE;
      chord_on    = 1'b0;
   endfunction

   // every note follows its own key edges, release wins for one frame
   function automatic void chord_update();
      logic p;
      logic c;
      for (int n = 0; n < NOTES; n++) begin
         p = keys_prev[n];
         c = keys_now[n];
         if (note_st[n] == kbnpt_pkg::ST_RELEASED) note_st[n] = kbnpt_pkg::ST_STILL;
         else if (p && c) note_st[n] = kbnpt_pkg::ST_HELD;
         else if (!p && c) note_st[n] = kbnpt_pkg::ST_PRESSED;
         else if (p && !c) note_st[n] = kbnpt_pkg::ST_RELEASED;
      end
   endfunction

   // last-note priority with upward scan
   function automatic void solo_update(logic octave);
      int   cur;
      int   pressed;
      int   held;
      bit   released;
      bit   stop;
      logic p;
      logic c;
      cur      = lowest_active();
      pressed  = -1;
      held     = -1;
      released = 1'b0;
      stop     = 1'b0;
      if (cur >= 0) begin
         prior_note  = kbnpt_pkg::IDX_W'(cur);
         prior_valid = 1'b1;
         prior_st    = note_st[cur];
      end else begin
         prior_st = kbnpt_pkg::ST_IDLE;
      end
      for (int n = 0; n < NOTES && !stop; n++) begin
         p = keys_prev[n];
         c = keys_now[n];
         if (p && c) begin
            held = n;
         end else if (!p && c) begin
            pressed = n;
            stop    = 1'b1;
         end else if (p && !c) begin
            released   = 1'b1;
            note_st[n] = kbnpt_pkg::ST_RELEASED;
         end else begin
            note_st[n] = kbnpt_pkg::ST_STILL;
         end
      end
      // octave change retriggers the held note in place of a press
      if (octave && lowest_active() >= 0) begin
         pressed = held;
         held    = -1;
      end
      if (pressed >= 0) begin
         silence_all();
         note_st[pressed] = kbnpt_pkg::ST_PRESSED;
      end else if (held >= 0) begin
         cur = lowest_active();
         silence_all();
         if (released) begin
            if (held == cur) note_st[held] = kbnpt_pkg::ST_HELD;
            else note_st[held] = kbnpt_pkg::ST_PRESSED;
         end else if (cur >= 0) begin
            note_st[cur] = kbnpt_pkg::ST_HELD;
         end
      end
   endfunction

   function automatic kbnpt_pkg::rsp_type note_step(kbnpt_pkg::req_type beat);
      kbnpt_pkg::rsp_type o;
      int                 cur;
      case (beat.opcode)
         kbnpt_pkg::OP_FRAME: begin
            keys_prev = keys_now;
            keys_now  = beat.key_mask;
            if (chord_on) chord_update();
            else solo_update(beat.octave_changed);
         end
         kbnpt_pkg::OP_KILL: begin
            silence_all();
         end
         kbnpt_pkg::OP_NO_ATTACK: begin
            cur = lowest_active();
            if (cur >= 0 && note_st[cur] == kbnpt_pkg::ST_PRESSED) begin
               note_st[cur] = kbnpt_pkg::ST_HELD;
            end
         end
         default: begin
            // unused opcode leaves the state alone
         end
      endcase
      o = '0;
      for (int n = 0; n < NOTES; n++) begin
         case (note_st[n])
            kbnpt_pkg::ST_PRESSED:  o.pressed_mask[n] = 1'b1;
            kbnpt_pkg::ST_HELD:     o.held_mask[n] = 1'b1;
            kbnpt_pkg::ST_RELEASED: o.released_mask[n] = 1'b1;
            kbnpt_pkg::ST_STILL:    o.still_released_mask[n] = 1'b1;
            default: begin
            end
         endcase
      end
      cur = lowest_active();
      if (cur >= 0) begin
         o.current_note  = kbnpt_pkg::IDX_W'(cur);
         o.current_valid = 1'b1;
         o.legato        = prior_st == kbnpt_pkg::ST_HELD
                           && note_st[cur] == kbnpt_pkg::ST_PRESSED;
      end
      o.last_note       = prior_note;
      o.last_note_valid = prior_valid;
      o.last_note_state = prior_st;
      o.any_pressed     = |o.pressed_mask;
      return o;
   endfunction

   function automatic logic [kbnpt_pkg::KEY_W-1:0] rand_keys();
      return {1'($urandom_range(0, 1)), $urandom()};
   endfunction

   // mostly playable key sequences, some noise and commands
   function automatic kbnpt_pkg::req_type random_beat();
      kbnpt_pkg::req_type b;
      int                 pick;
      pick             = $urandom_range(0, 99);
      b.opcode         = kbnpt_pkg::OP_FRAME;
      b.octave_changed = ($urandom_range(0, 6) == 0);
      if (pick < 45) begin
         if ($countones(stim_keys) > 3) stim_keys = stim_keys & (stim_keys - 1'b1);
         else stim_keys = stim_keys ^ (kbnpt_pkg::KEY_W'(1)
                                       << $urandom_range(0, kbnpt_pkg::KEY_W - 1));
      end else if (pick < 62) begin
         // keys unchanged, notes held
      end else if (pick < 72) begin
         stim_keys = rand_keys();
      end else if (pick < 77) begin
         stim_keys = $urandom_range(0, 1) ? KEYS_ALL : '0;
      end else if (pick < 87) begin
         b.opcode = kbnpt_pkg::OP_KILL;
      end else if (pick < 97) begin
         b.opcode = kbnpt_pkg::OP_NO_ATTACK;
      end else begin
         b.opcode = OP_UNUSED;
      end
      b.key_mask = (b.opcode == kbnpt_pkg::OP_FRAME) ? stim_keys : rand_keys();
      return b;
   endfunction

   // sender bursts with random gaps, entered and left at a falling edge
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic offer(input kbnpt_pkg::req_type beat, input logic typed,
                        input kbnpt_pkg::rsp_type want);
      kbnpt_pkg::rsp_type pred;
      req_data  <= beat;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = note_step(beat);
      rsp_due.push_back(typed ? want : pred);
      @(negedge clock);
   endtask

   // mode write only once the pipe has drained
   task automatic write_mode(input logic mode);
      req_valid <= 1'b0;
      while (rsp_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_data  <= mode;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      chord_on = mode;
      silence_all();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // receiver stall patterns plus one long hold-off
   initial begin : receiver
      rx_pattern_type rx_mode;
      int             mode_left;
      int             hold_left;
      int             tick;
      bit             hold_done;
      rsp_ready = 1'b0;
      rx_mode   = RX_OPEN;
      mode_left = 0;
      hold_left = 0;
      tick      = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (long_hold_arm && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (mode_left == 0) begin
            rx_mode   = rx_pattern_type'($urandom_range(0, 3));
            mode_left = $urandom_range(8, 80);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= (tick % 4 == 0);
               default:   rsp_ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // response beat check against the oldest expectation
   always @(posedge clock) begin : response_check
      kbnpt_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_due.size() == 0) begin
            $display("%0t unexpected response beat, actual %h", $time, rsp_data);
            mismatches++;
         end else begin
            want = rsp_due.pop_front();
            check_field("pressed_mask", want.pressed_mask, rsp_data.pressed_mask);
            check_field("held_mask", want.held_mask, rsp_data.held_mask);
            check_field("released_mask", want.released_mask, rsp_data.released_mask);
            check_field("still_released_mask", want.still_released_mask,
                        rsp_data.still_released_mask);
            check_field("current_note", want.current_note, rsp_data.current_note);
            check_field("current_valid", want.current_valid, rsp_data.current_valid);
            check_field("last_note", want.last_note, rsp_data.last_note);
            check_field("last_note_valid", want.last_note_valid, rsp_data.last_note_valid);
            check_field("last_note_state", want.last_note_state, rsp_data.last_note_state);
            check_field("legato", want.legato, rsp_data.legato);
            check_field("any_pressed", want.any_pressed, rsp_data.any_pressed);
         end
      end
   end

   // stimulus: directed table, then random phases, the first in chord mode, the second in solo, the rest random
   initial begin : stimulus
      kbnpt_pkg::req_type beat;
      int                 counted;
      logic               mode;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = 1'b0;
      notes_reset();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (DIR_TAB[i].kind == ROW_MODE) begin
            write_mode(DIR_TAB[i].mode);
         end else begin
            beat = '{DIR_TAB[i].op, DIR_TAB[i].keys, DIR_TAB[i].octave};
            pace();
            offer(beat, DIR_TAB[i].typed, DIR_TAB[i].want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < 2) mode = (ph == 0);
         else mode = 1'($urandom_range(0, 1));
         write_mode(mode);
         if (ph == 2) long_hold_arm = 1'b1;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            beat = random_beat();
            if (beat.opcode != OP_UNUSED) counted++;
            pace();
            offer(beat, 1'b0, RSP_NONE);
         end
      end

      // drain and settle
      req_valid <= 1'b0;
      while (rsp_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES * 2) @(negedge clock);
      if (mismatches == 0 && rsp_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/kbnpt_pkg.sv
hdl/kbnpt_next.sv
hdl/kbnpt_report.sv
hdl/keyboard_note_priority_tracker.sv
tb/sv/tb_top.sv
